// ===== hw/rtl/gccl_pkg.sv =====
// Shared types and constants for the glyph coverage and class lookup block.
// Used by the top level and by its port checker; depends on nothing else.
package gccl_pkg;

  // Width of a byte address formed during a table walk (record base plus index times six).
  localparam int ADDR_W = 20;
  // Width of the effective table length: TABLE_BYTES is at most 65536.
  localparam int LIM_W  = 17;

  localparam logic [15:0] FMT_ARRAY = 16'd1;
  localparam logic [15:0] FMT_RANGE = 16'd2;

  typedef enum logic [1:0] {
    CMD_WRITE = 2'd0,
    CMD_COVER = 2'd1,
    CMD_CLASS = 2'd2,
    CMD_NONE  = 2'd3
  } cmd_e;

  typedef struct packed {
    cmd_e        command;
    logic [11:0] table_offset;
    logic [7:0]  write_byte;
    logic [15:0] glyph_code;
  } in_word_t;

  typedef struct packed {
    logic        found;
    logic [16:0] result_value;
  } out_word_t;

  typedef enum logic [3:0] {
    ST_IDLE,
    ST_RD_A,
    ST_RD_B,
    ST_RD_C,
    ST_FMT,
    ST_CNT,
    ST_MID,
    ST_G1,
    ST_RS,
    ST_RE,
    ST_RV,
    ST_C1S,
    ST_C1N,
    ST_C1V,
    ST_OUT
  } state_e;

endpackage

// ===== hw/rtl/glyph_coverage_class_lookup.sv =====
// Glyph coverage and class lookup over a byte table held in on-chip memory.
// Uses gccl_pkg for the word types, commands and sequencer states.
//
// Usage:
//   Input channel (in_valid_i/in_ready_o/in_data_i) carries one word per command.
//   A write word stores write_byte at table_offset and returns nothing; the
//   block stays idle. Coverage and class words walk the table at table_offset
//   and return one output word (found, result_value) on out_valid_o/out_ready_i.
//   The config channel sets the valid table length; 16-bit reads that reach past
//   it return zero. It is always ready and should only be written while idle.
//   Every 16-bit table read goes through the single memory read port as two
//   byte reads, one registered merge and one decision step, and the sequencer
//   issues them one after another. Coverage lookups binary-search a glyph
//   array or range records; a class array lookup reads its entry directly.
//   in_ready_o is low while a lookup runs. A finished result sits in the output
//   register, and the block takes further words while it waits there; a second
//   result holds the sequencer until the first is taken.
//   Reset clears the control state and the table length; table contents are
//   undefined until written.
module glyph_coverage_class_lookup
  import gccl_pkg::*;
#(
  parameter int TABLE_BYTES = 4096
) (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        cfg_valid_i,
  output logic        cfg_ready_o,
  input  logic [12:0] cfg_data_i,
  input  logic        in_valid_i,
  output logic        in_ready_o,
  input  in_word_t    in_data_i,
  output logic        out_valid_o,
  input  logic        out_ready_i,
  output out_word_t   out_data_o
);

  localparam int AW = $clog2(TABLE_BYTES);

  logic [7:0] mem_q [TABLE_BYTES];
  logic [7:0] rdata_q;

  state_e state_q, state_d, ret_q, ret_d;
  logic [LIM_W-1:0]  lim_q;
  logic [ADDR_W-1:0] addr_q, addr_d, rec_q, rec_d;
  logic              oor_q, oor_d;
  logic [7:0]        hbyte_q, hbyte_d;
  logic [15:0]       word_q, word_d;
  logic [11:0]       base_q, base_d;
  logic [15:0]       glyph_q, glyph_d;
  cmd_e              mode_q, mode_d;
  logic              fmt2_q, fmt2_d;
  logic [15:0]       lo_q, lo_d, hi_q, hi_d, mid_q, mid_d, s_q, s_d;
  logic              found_q, found_d;
  logic [16:0]       val_q, val_d;
  logic              out_valid_q, out_valid_d;
  out_word_t         out_data_q, out_data_d;

  logic              in_acc;
  logic [ADDR_W-1:0] addr_p1, base_ext, rec2_addr, rec6_addr, c1v_addr;
  logic [16:0]       mid_sum;
  logic [15:0]       mid_w, g_minus_s;
  logic              search_go, glyph_lt_s, glyph_gt_e, c1_miss, out_free;
  logic [AW-1:0]     rd_idx;

  assign cfg_ready_o = 1'b1;
  assign in_ready_o  = (state_q == ST_IDLE);
  assign in_acc      = in_valid_i && in_ready_o;
  assign out_valid_o = out_valid_q;
  assign out_data_o  = out_data_q;
  assign out_free    = !out_valid_q || out_ready_i;

  assign addr_p1    = addr_q + ADDR_W'(1);
  assign base_ext   = ADDR_W'(base_q);
  assign mid_sum    = 17'(lo_q) + 17'(hi_q);
  assign mid_w      = mid_sum[16:1];
  assign rec2_addr  = base_ext + ADDR_W'(4) + (ADDR_W'(mid_w) << 1);
  assign rec6_addr  = base_ext + ADDR_W'(4) + (ADDR_W'(mid_w) << 2) + (ADDR_W'(mid_w) << 1);
  assign g_minus_s  = glyph_q - s_q;
  assign c1v_addr   = base_ext + ADDR_W'(6) + (ADDR_W'(g_minus_s) << 1);
  assign search_go  = lo_q < hi_q;
  assign glyph_lt_s = glyph_q < s_q;
  assign glyph_gt_e = glyph_q > word_q;
  assign c1_miss    = glyph_lt_s || (17'(glyph_q) >= 17'(s_q) + 17'(word_q));

  // Memory: one write port for loading, one registered read port for the walk.
  assign rd_idx = (state_q == ST_RD_B) ? addr_p1[AW-1:0] : addr_q[AW-1:0];

  always_ff @(posedge clk_i) begin
    if (in_acc && in_data_i.command == CMD_WRITE &&
        17'(in_data_i.table_offset) < 17'(TABLE_BYTES)) begin
      mem_q[AW'(in_data_i.table_offset)] <= in_data_i.write_byte;
    end
    rdata_q <= mem_q[rd_idx];
  end

  // Next state.
  always_comb begin
    state_d = state_q;
    ret_d   = ret_q;
    case (state_q)
      ST_IDLE: begin
        if (in_acc) begin
          case (in_data_i.command)
            CMD_COVER: begin
              state_d = ST_RD_A;
              ret_d   = ST_FMT;
            end
            CMD_CLASS: begin
              if (in_data_i.table_offset == 12'd0) begin
                state_d = ST_OUT;
              end else begin
                state_d = ST_RD_A;
                ret_d   = ST_FMT;
              end
            end
            default: state_d = ST_IDLE;
          endcase
        end
      end
      ST_RD_A: state_d = ST_RD_B;
      ST_RD_B: state_d = ST_RD_C;
      ST_RD_C: state_d = ret_q;
      ST_FMT: begin
        if (word_q == FMT_RANGE) begin
          state_d = ST_RD_A;
          ret_d   = ST_CNT;
        end else if (word_q == FMT_ARRAY) begin
          state_d = ST_RD_A;
          ret_d   = (mode_q == CMD_COVER) ? ST_CNT : ST_C1S;
        end else begin
          state_d = ST_OUT;
        end
      end
      ST_CNT: state_d = ST_MID;
      ST_MID: begin
        if (search_go) begin
          state_d = ST_RD_A;
          ret_d   = fmt2_q ? ST_RS : ST_G1;
        end else begin
          state_d = ST_OUT;
        end
      end
      ST_G1: state_d = (word_q == glyph_q) ? ST_OUT : ST_MID;
      ST_RS: begin
        state_d = ST_RD_A;
        ret_d   = ST_RE;
      end
      ST_RE: begin
        if (glyph_lt_s || glyph_gt_e) begin
          state_d = ST_MID;
        end else begin
          state_d = ST_RD_A;
          ret_d   = ST_RV;
        end
      end
      ST_RV: state_d = ST_OUT;
      ST_C1S: begin
        state_d = ST_RD_A;
        ret_d   = ST_C1N;
      end
      ST_C1N: begin
        if (c1_miss) begin
          state_d = ST_OUT;
        end else begin
          state_d = ST_RD_A;
          ret_d   = ST_C1V;
        end
      end
      ST_C1V: state_d = ST_OUT;
      ST_OUT: begin
        if (out_free) state_d = ST_IDLE;
      end
      default: state_d = ST_IDLE;
    endcase
  end

  // Datapath and outputs.
  always_comb begin
    addr_d      = addr_q;
    rec_d       = rec_q;
    oor_d       = oor_q;
    hbyte_d     = hbyte_q;
    word_d      = word_q;
    base_d      = base_q;
    glyph_d     = glyph_q;
    mode_d      = mode_q;
    fmt2_d      = fmt2_q;
    lo_d        = lo_q;
    hi_d        = hi_q;
    mid_d       = mid_q;
    s_d         = s_q;
    found_d     = found_q;
    val_d       = val_q;
    out_valid_d = out_valid_q && !out_ready_i;
    out_data_d  = out_data_q;
    case (state_q)
      ST_IDLE: begin
        if (in_acc) begin
          base_d  = in_data_i.table_offset;
          glyph_d = in_data_i.glyph_code;
          mode_d  = in_data_i.command;
          addr_d  = ADDR_W'(in_data_i.table_offset);
          found_d = 1'b0;
          val_d   = 17'd0;
        end
      end
      // A 16-bit read whose two bytes do not both lie inside the table reads zero.
      ST_RD_A: oor_d   = (21'(addr_q) + 21'd2) > 21'(lim_q);
      ST_RD_B: hbyte_d = rdata_q;
      ST_RD_C: word_d  = oor_q ? 16'd0 : {hbyte_q, rdata_q};
      ST_FMT: begin
        fmt2_d = (word_q == FMT_RANGE);
        addr_d = base_ext + ADDR_W'(2);
      end
      ST_CNT: begin
        hi_d = word_q;
        lo_d = 16'd0;
      end
      ST_MID: begin
        mid_d  = mid_w;
        rec_d  = rec6_addr;
        addr_d = fmt2_q ? rec6_addr : rec2_addr;
      end
      ST_G1: begin
        if (word_q == glyph_q) begin
          found_d = 1'b1;
          val_d   = 17'(mid_q);
        end else if (word_q < glyph_q) begin
          lo_d = mid_q + 16'd1;
        end else begin
          hi_d = mid_q;
        end
      end
      ST_RS: begin
        s_d    = word_q;
        addr_d = rec_q + ADDR_W'(2);
      end
      ST_RE: begin
        if (glyph_lt_s) begin
          hi_d = mid_q;
        end else if (glyph_gt_e) begin
          lo_d = mid_q + 16'd1;
        end else begin
          addr_d = rec_q + ADDR_W'(4);
        end
      end
      ST_RV: begin
        found_d = 1'b1;
        val_d   = (mode_q == CMD_COVER) ? 17'(word_q) + 17'(g_minus_s) : 17'(word_q);
      end
      ST_C1S: begin
        s_d    = word_q;
        addr_d = base_ext + ADDR_W'(4);
      end
      ST_C1N: addr_d = c1v_addr;
      ST_C1V: begin
        found_d = 1'b1;
        val_d   = 17'(word_q);
      end
      ST_OUT: begin
        if (out_free) begin
          out_valid_d             = 1'b1;
          out_data_d.found        = found_q;
          out_data_d.result_value = val_q;
        end
      end
      default: ;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= ST_IDLE;
      ret_q       <= ST_IDLE;
      out_valid_q <= 1'b0;
      lim_q       <= '0;
    end else begin
      state_q     <= state_d;
      ret_q       <= ret_d;
      out_valid_q <= out_valid_d;
      if (cfg_valid_i && cfg_ready_o) begin
        lim_q <= (17'(cfg_data_i) < 17'(TABLE_BYTES)) ? 17'(cfg_data_i) : 17'(TABLE_BYTES);
      end
    end
  end

  always_ff @(posedge clk_i) begin
    addr_q     <= addr_d;
    rec_q      <= rec_d;
    oor_q      <= oor_d;
    hbyte_q    <= hbyte_d;
    word_q     <= word_d;
    base_q     <= base_d;
    glyph_q    <= glyph_d;
    mode_q     <= mode_d;
    fmt2_q     <= fmt2_d;
    lo_q       <= lo_d;
    hi_q       <= hi_d;
    mid_q      <= mid_d;
    s_q        <= s_d;
    found_q    <= found_d;
    val_q      <= val_d;
    out_data_q <= out_data_d;
  end

endmodule

// ===== hw/rtl/gccl_checker.sv =====
// Port-level checks for glyph_coverage_class_lookup, attached by bind.
// Depends on gccl_pkg for the word types and command codes.
module gccl_checker
  import gccl_pkg::*;
(
  input logic      clk_i,
  input logic      rst_ni,
  input logic      in_valid_i,
  input logic      in_ready_o,
  input in_word_t  in_data_i,
  input logic      out_valid_o,
  input logic      out_ready_i,
  input out_word_t out_data_o
);

  // A stalled result word keeps its contents.
  a_out_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && !out_ready_i |=> out_valid_o && $stable(out_data_o))
    else $error("stalled output word changed");

  // A result that is not found always reads zero.
  a_miss_zero: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && !out_data_o.found |-> out_data_o.result_value == 17'd0)
    else $error("miss with nonzero value");

  // A lookup word keeps the input side busy in the following cycle.
  a_lookup_busy: assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_valid_i && in_ready_o &&
    (in_data_i.command == CMD_COVER || in_data_i.command == CMD_CLASS) |=> !in_ready_o)
    else $error("ready right after lookup");

  // A write word or an empty word (CMD_NONE) does not hold up the input side.
  a_write_free: assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_valid_i && in_ready_o &&
    (in_data_i.command == CMD_WRITE || in_data_i.command == CMD_NONE) |=> in_ready_o)
    else $error("busy after write");

  // A new result only appears out of a running lookup.
  a_result_origin: assert property (@(posedge clk_i) disable iff (!rst_ni)
    $rose(out_valid_o) |-> $past(!in_ready_o))
    else $error("result without lookup");

endmodule

bind glyph_coverage_class_lookup gccl_checker u_gccl_checker (
  .clk_i       (clk_i),
  .rst_ni      (rst_ni),
  .in_valid_i  (in_valid_i),
  .in_ready_o  (in_ready_o),
  .in_data_i   (in_data_i),
  .out_valid_o (out_valid_o),
  .out_ready_i (out_ready_i),
  .out_data_o  (out_data_o)
);
